[src/tcphp_pkg.sv]
`timescale 1ns / 1ps

package tcphp_pkg;

	localparam int MIN_SEGMENT  = 20;
	localparam int MAX_SEGMENT  = 65535;
	localparam int MAX_OPTIONS  = 40;
	localparam int FIXED_HEADER = 20;
	localparam int MIN_HDR_WORDS = 5;

	typedef struct packed {
		logic        status;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_number;
		logic [3:0]  header_words;
		logic [11:0] control_flags;
		logic [15:0] rx_window;
		logic [15:0] checksum;
		logic [15:0] urg_ptr;
		logic [5:0]  option_count;
		logic [15:0] payload_len;
	} tcphp_result_t;

endpackage

[src/tcphp_core.sv]
`timescale 1ns / 1ps

module tcphp_core
	import tcphp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output tcphp_result_t result
);

	localparam logic [1:0] PH_KIND = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [15:0] MAX_POS  = 16'(MAX_SEGMENT);
	localparam logic [5:0]  MAX_OPTS = 6'(MAX_OPTIONS);
	localparam logic [15:0] MIN_LEN  =
		16'((MIN_SEGMENT > FIXED_HEADER) ? MIN_SEGMENT : FIXED_HEADER);
	localparam logic [15:0] FIXED_LEN = 16'(FIXED_HEADER);

	logic [15:0] pos_q, pos_n;
	logic [15:0] src_q, src_n;
	logic [15:0] dst_q, dst_n;
	logic [31:0] seq_q, seq_n;
	logic [31:0] ack_q, ack_n;
	logic [3:0]  hw_q, hw_n;
	logic [11:0] ctrl_q, ctrl_n;
	logic [15:0] win_q, win_n;
	logic [15:0] csum_q, csum_n;
	logic [15:0] urg_q, urg_n;
	logic [1:0]  phase_q, phase_n;
	logic [7:0]  left_q, left_n;
	logic [5:0]  seen_q, seen_n;
	logic        err_q, err_n;

	logic [16:0] hdr_end;
	logic [16:0] len_hdr;
	logic [16:0] opt_end;
	logic        bad;

	assign hdr_end = {11'd0, hw_q, 2'b00};
	assign opt_end = {1'b0, pos_q} - 17'd1 + {9'd0, data_byte};

	always_comb begin
		pos_n   = pos_q;
		src_n   = src_q;
		dst_n   = dst_q;
		seq_n   = seq_q;
		ack_n   = ack_q;
		hw_n    = hw_q;
		ctrl_n  = ctrl_q;
		win_n   = win_q;
		csum_n  = csum_q;
		urg_n   = urg_q;
		phase_n = phase_q;
		left_n  = left_q;
		seen_n  = seen_q;
		err_n   = err_q;
		if (pos_q >= MAX_POS) begin
			err_n = 1'b1;
		end else begin
			pos_n = pos_q + 16'd1;
			if (pos_q < FIXED_LEN) begin
				case (pos_q[4:0])
					5'd0, 5'd1: src_n = {src_q[7:0], data_byte};
					5'd2, 5'd3: dst_n = {dst_q[7:0], data_byte};
					5'd4, 5'd5, 5'd6, 5'd7: seq_n = {seq_q[23:0], data_byte};
					5'd8, 5'd9, 5'd10, 5'd11: ack_n = {ack_q[23:0], data_byte};
					5'd12: begin
						hw_n   = data_byte[7:4];
						ctrl_n = {data_byte[3:0], 8'd0};
					end
					5'd13: ctrl_n = {ctrl_q[11:8], data_byte};
					5'd14, 5'd15: win_n = {win_q[7:0], data_byte};
					5'd16, 5'd17: csum_n = {csum_q[7:0], data_byte};
					default: urg_n = {urg_q[7:0], data_byte};
				endcase
			end else if ({1'b0, pos_q} < hdr_end) begin
				case (phase_q)
					PH_KIND: begin
						if (seen_q >= MAX_OPTS) begin
							phase_n = PH_DONE;
						end else begin
							seen_n = seen_q + 6'd1;
							if (data_byte == 8'd0) begin
								phase_n = PH_DONE;
							end else if (data_byte == 8'd1) begin
								phase_n = PH_KIND;
							end else if ({1'b0, pos_q} + 17'd1 >= hdr_end) begin
								err_n   = 1'b1;
								phase_n = PH_DONE;
							end else begin
								phase_n = PH_LEN;
							end
						end
					end
					PH_LEN: begin
						if (data_byte < 8'd2 || opt_end > hdr_end) begin
							err_n   = 1'b1;
							phase_n = PH_DONE;
						end else begin
							left_n  = data_byte - 8'd2;
							phase_n = (data_byte == 8'd2) ? PH_KIND : PH_DATA;
						end
					end
					PH_DATA: begin
						if (left_q > 8'd0) begin
							left_n = left_q - 8'd1;
						end
						if (left_q <= 8'd1) begin
							phase_n = PH_KIND;
						end
					end
					default: phase_n = PH_DONE;
				endcase
			end
		end
	end

	assign len_hdr = {1'b0, pos_n} - {11'd0, hw_n, 2'b00};
	assign bad = err_n || (pos_n < MIN_LEN) || (hw_n < 4'(MIN_HDR_WORDS)) || len_hdr[16];

	always_comb begin
		result.status        = bad;
		result.src_port      = src_n;
		result.dst_port      = dst_n;
		result.seq_num       = seq_n;
		result.ack_number    = ack_n;
		result.header_words  = hw_n;
		result.control_flags = ctrl_n;
		result.rx_window     = win_n;
		result.checksum      = csum_n;
		result.urg_ptr       = urg_n;
		result.option_count  = seen_n;
		result.payload_len   = bad ? 16'd0 : len_hdr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			seq_q   <= '0;
			ack_q   <= '0;
			hw_q    <= '0;
			ctrl_q  <= '0;
			win_q   <= '0;
			csum_q  <= '0;
			urg_q   <= '0;
			phase_q <= PH_KIND;
			left_q  <= '0;
			seen_q  <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				pos_q   <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				seq_q   <= '0;
				ack_q   <= '0;
				hw_q    <= '0;
				ctrl_q  <= '0;
				win_q   <= '0;
				csum_q  <= '0;
				urg_q   <= '0;
				phase_q <= PH_KIND;
				left_q  <= '0;
				seen_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				seq_q   <= seq_n;
				ack_q   <= ack_n;
				hw_q    <= hw_n;
				ctrl_q  <= ctrl_n;
				win_q   <= win_n;
				csum_q  <= csum_n;
				urg_q   <= urg_n;
				phase_q <= phase_n;
				left_q  <= left_n;
				seen_q  <= seen_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

[src/tcp_header_parser_top.sv]
`timescale 1ns / 1ps

// Parses a TCP segment delivered one byte per beat, with last_byte set on the final byte,
// and returns one result beat per segment carrying the fixed header fields, the number of
// options walked, the payload length and a status bit that is set for a malformed segment.
// The block takes one byte every cycle while input is not stalled; the result beat is presented
// once the final byte has passed through the input register and then the result
// register. A waiting result stalls input only when the next final byte reaches the parser
// while it is still untaken.

module tcp_header_parser_top
	import tcphp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        status,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [31:0] seq_num,
	output logic [31:0] ack_number,
	output logic [3:0]  header_words,
	output logic [11:0] control_flags,
	output logic [15:0] rx_window,
	output logic [15:0] checksum,
	output logic [15:0] urg_ptr,
	output logic [5:0]  option_count,
	output logic [15:0] payload_len
);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic          advance;
	logic          step;
	logic          res_valid_q;
	tcphp_result_t res_n;
	tcphp_result_t res_q;

	assign advance    = !last_s1 || !res_valid_q || result_ready;
	assign step       = valid_s1 && advance;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	tcphp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res_n;
		end
	end

	assign result_valid  = res_valid_q;
	assign status        = res_q.status;
	assign src_port      = res_q.src_port;
	assign dst_port      = res_q.dst_port;
	assign seq_num       = res_q.seq_num;
	assign ack_number    = res_q.ack_number;
	assign header_words  = res_q.header_words;
	assign control_flags = res_q.control_flags;
	assign rx_window     = res_q.rx_window;
	assign checksum      = res_q.checksum;
	assign urg_ptr       = res_q.urg_ptr;
	assign option_count  = res_q.option_count;
	assign payload_len   = res_q.payload_len;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import tcphp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_BYTES = 1230;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	typedef enum logic [1:0] {OPT_KIND, OPT_LEN, OPT_DATA, OPT_DONE} opt_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        status;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [31:0] seq_num;
	logic [31:0] ack_number;
	logic [3:0]  header_words;
	logic [11:0] control_flags;
	logic [15:0] rx_window;
	logic [15:0] checksum;
	logic [15:0] urg_ptr;
	logic [5:0]  option_count;
	logic [15:0] payload_len;

	tcp_header_parser_top dut (.*);

	// Byte stream waiting to be driven, and the header results still owed by the block.
	wire_byte_t    byte_backlog[$];
	logic [7:0]    segment_draft[$];
	tcphp_result_t expected_headers[$];
	tcphp_result_t want;
	wire_byte_t    next_beat;

	// Parser state of the prediction.
	logic [15:0] byte_position;
	logic [15:0] held_sport;
	logic [15:0] held_dport;
	logic [31:0] held_seq;
	logic [31:0] held_ack;
	logic [3:0]  held_words;
	logic [11:0] held_control;
	logic [15:0] held_window;
	logic [15:0] held_csum;
	logic [15:0] held_urgent;
	opt_phase_t  opt_phase;
	logic [7:0]  opt_left;
	logic [5:0]  opts_seen;
	logic        seg_error;

	int mismatches = 0;
	int results_checked = 0;
	int bad_results = 0;
	int bytes_parsed = 0;
	int random_bytes = 0;
	int burst_left = 0;
	int gap_left = 0;
	int quiet_cycles = 0;
	logic [7:0] ready_phase = 8'h00;
	logic [1:0] ready_mode = 2'd0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic clear_parser();
		byte_position = '0;
		held_sport = '0;
		held_dport = '0;
		held_seq = '0;
		held_ack = '0;
		held_words = '0;
		held_control = '0;
		held_window = '0;
		held_csum = '0;
		held_urgent = '0;
		opt_phase = OPT_KIND;
		opt_left = '0;
		opts_seen = '0;
		seg_error = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic last);
		int p;
		int hdr_end;
		int len;
		logic bad;
		tcphp_result_t r;
		p = int'(byte_position);
		hdr_end = int'(held_words) * 4;
		if (p >= MAX_SEGMENT) begin
			seg_error = 1'b1;
		end else begin
			byte_position = byte_position + 16'd1;
			if (p < 2) begin
				held_sport = {held_sport[7:0], b};
			end else if (p < 4) begin
				held_dport = {held_dport[7:0], b};
			end else if (p < 8) begin
				held_seq = {held_seq[23:0], b};
			end else if (p < 12) begin
				held_ack = {held_ack[23:0], b};
			end else if (p == 12) begin
				held_words = b[7:4];
				held_control = {b[3:0], 8'h00};
			end else if (p == 13) begin
				held_control[7:0] = b;
			end else if (p < 16) begin
				held_window = {held_window[7:0], b};
			end else if (p < 18) begin
				held_csum = {held_csum[7:0], b};
			end else if (p < FIXED_HEADER) begin
				held_urgent = {held_urgent[7:0], b};
			end else if (p < hdr_end) begin
				case (opt_phase)
					OPT_KIND: begin
						if (opts_seen >= MAX_OPTIONS) begin
							opt_phase = OPT_DONE;
						end else begin
							opts_seen = opts_seen + 6'd1;
							if (b == 8'd0) begin
								opt_phase = OPT_DONE;
							end else if (b == 8'd1) begin
								opt_phase = OPT_KIND;
							end else if (p + 1 >= hdr_end) begin
								seg_error = 1'b1;
								opt_phase = OPT_DONE;
							end else begin
								opt_phase = OPT_LEN;
							end
						end
					end
					OPT_LEN: begin
						if (b < 8'd2 || (p - 1) + int'(b) > hdr_end) begin
							seg_error = 1'b1;
							opt_phase = OPT_DONE;
						end else begin
							opt_left = b - 8'd2;
							opt_phase = (b == 8'd2) ? OPT_KIND : OPT_DATA;
						end
					end
					OPT_DATA: begin
						if (opt_left != 8'd0) opt_left = opt_left - 8'd1;
						if (opt_left == 8'd0) opt_phase = OPT_KIND;
					end
					default: ;
				endcase
			end
		end
		if (last) begin
			len = int'(byte_position);
			bad = seg_error || len < MIN_SEGMENT || len < FIXED_HEADER ||
				held_words < MIN_HDR_WORDS || int'(held_words) * 4 > len;
			r.status = bad;
			r.src_port = held_sport;
			r.dst_port = held_dport;
			r.seq_num = held_seq;
			r.ack_number = held_ack;
			r.header_words = held_words;
			r.control_flags = held_control;
			r.rx_window = held_window;
			r.checksum = held_csum;
			r.urg_ptr = held_urgent;
			r.option_count = opts_seen;
			r.payload_len = bad ? 16'd0 : 16'(len - int'(held_words) * 4);
			expected_headers.push_back(r);
			clear_parser();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] wanted);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, wanted);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] wanted);
		if (got !== wanted) report_mismatch(what, got, wanted);
	endtask

	task automatic put_header(input logic [3:0] words);
		logic [7:0] b;
		for (int i = 0; i < FIXED_HEADER; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i == 12) b[7:4] = words;
			segment_draft.push_back(b);
		end
	endtask

	task automatic put_random(input int count);
		for (int i = 0; i < count; i++) segment_draft.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_filled(input int count, input logic [7:0] b);
		for (int i = 0; i < count; i++) segment_draft.push_back(b);
	endtask

	task automatic put_options(input int space, input logic broken);
		int rem;
		int olen;
		rem = space;
		while (rem > 0) begin
			if (broken && $urandom_range(0, 3) == 0) begin
				segment_draft.push_back(8'($urandom_range(2, 255)));
				rem--;
				if (rem > 0) begin
					segment_draft.push_back(8'($urandom_range(0, 255)));
					rem--;
				end
			end else if ($urandom_range(0, 11) == 0) begin
				segment_draft.push_back(8'd0);
				put_random(rem - 1);
				rem = 0;
			end else if (rem < 2 || $urandom_range(0, 2) == 0) begin
				segment_draft.push_back(8'd1);
				rem--;
			end else begin
				olen = $urandom_range(2, rem);
				segment_draft.push_back(8'($urandom_range(2, 255)));
				segment_draft.push_back(8'(olen));
				put_random(olen - 2);
				rem -= olen;
			end
		end
	endtask

	task automatic close_segment();
		wire_byte_t beat;
		foreach (segment_draft[i]) begin
			beat.data = segment_draft[i];
			beat.last = (i == segment_draft.size() - 1);
			byte_backlog.push_back(beat);
		end
		segment_draft.delete();
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!byte_valid || byte_ready) begin
			if (gap_left != 0 || byte_backlog.size() == 0) begin
				byte_valid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end else begin
				next_beat = byte_backlog.pop_front();
				byte_valid <= 1'b1;
				data_byte <= next_beat.data;
				last_byte <= next_beat.last;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: the stall mode is picked at random each time the ready_phase counter wraps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_phase <= 8'h00;
			ready_mode <= 2'd0;
		end else begin
			ready_phase <= ready_phase + 8'd1;
			if (ready_phase == 8'h00) ready_mode <= 2'($urandom_range(0, 3));
			case (ready_mode)
				2'd0: result_ready <= 1'b1;
				2'd1: result_ready <= ($urandom_range(0, 1) == 1);
				2'd2: result_ready <= (ready_phase[2:0] == 3'd7);
				default: result_ready <= ($urandom_range(0, 5) != 0);
			endcase
		end
	end

	// Results are checked before the byte of the same edge enters the prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_headers.size() == 0) begin
					report_mismatch("result beat with nothing expected", 32'd0, 32'd0);
				end else begin
					want = expected_headers.pop_front();
					results_checked++;
					if (want.status) bad_results++;
					check_field("status", 32'(status), 32'(want.status));
					check_field("src_port", 32'(src_port), 32'(want.src_port));
					check_field("dst_port", 32'(dst_port), 32'(want.dst_port));
					check_field("seq_num", seq_num, want.seq_num);
					check_field("ack_number", ack_number, want.ack_number);
					check_field("header_words", 32'(header_words), 32'(want.header_words));
					check_field("control_flags", 32'(control_flags),
						32'(want.control_flags));
					check_field("rx_window", 32'(rx_window), 32'(want.rx_window));
					check_field("checksum", 32'(checksum), 32'(want.checksum));
					check_field("urg_ptr", 32'(urg_ptr), 32'(want.urg_ptr));
					check_field("option_count", 32'(option_count), 32'(want.option_count));
					check_field("payload_len", 32'(payload_len), 32'(want.payload_len));
				end
			end
			if (byte_valid && byte_ready) begin
				parse_byte(data_byte, last_byte);
				bytes_parsed++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (byte_valid || byte_backlog.size() != 0 || expected_headers.size() != 0) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int words;
		int pick;
		clear_parser();

		put_header(4'd5);
		close_segment();
		for (int i = 0; i < FIXED_HEADER; i++) segment_draft.push_back(i == 12 ? 8'h5f : 8'hff);
		put_filled(6, 8'hff);
		close_segment();
		for (int i = 0; i < FIXED_HEADER; i++) segment_draft.push_back(i == 12 ? 8'h50 : 8'h00);
		close_segment();
		put_filled(20, 8'h00);
		close_segment();
		put_filled(70, 8'hff);
		close_segment();
		put_random(1);
		close_segment();
		put_header(4'd5);
		void'(segment_draft.pop_back());
		close_segment();
		put_header(4'd4);
		put_random(8);
		close_segment();

		// Full option area of no-operation options, then one byte short of the header.
		put_header(4'd15);
		put_filled(40, 8'd1);
		put_random(5);
		close_segment();
		put_header(4'd15);
		put_filled(39, 8'd1);
		close_segment();

		// End of list followed by ignored bytes.
		put_header(4'd6);
		segment_draft.push_back(8'd0);
		put_random(3);
		put_random(2);
		close_segment();

		// Maximum segment size, no-operation and window scale filling the header exactly.
		put_header(4'd7);
		segment_draft.push_back(8'd2);
		segment_draft.push_back(8'd4);
		put_random(2);
		segment_draft.push_back(8'd1);
		segment_draft.push_back(8'd3);
		segment_draft.push_back(8'd3);
		put_random(1);
		put_random(10);
		close_segment();

		// Option lengths of zero and one.
		put_header(4'd6);
		segment_draft.push_back(8'd2);
		segment_draft.push_back(8'd0);
		put_random(2);
		close_segment();
		put_header(4'd6);
		segment_draft.push_back(8'd8);
		segment_draft.push_back(8'd1);
		put_random(2);
		close_segment();

		// Option running past the header, then one that just fits.
		put_header(4'd6);
		segment_draft.push_back(8'd2);
		segment_draft.push_back(8'd5);
		put_random(2);
		close_segment();
		put_header(4'd6);
		segment_draft.push_back(8'd5);
		segment_draft.push_back(8'd4);
		put_random(2);
		put_random(3);
		close_segment();

		// A kind that needs a length byte sitting in the last header byte.
		put_header(4'd6);
		put_filled(3, 8'd1);
		segment_draft.push_back(8'd2);
		put_random(4);
		close_segment();

		while (random_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				words = $urandom_range(5, 15);
				put_header(4'(words));
				put_options(words * 4 - FIXED_HEADER, 1'b0);
				put_random(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24));
			end else if (pick < 17) begin
				words = $urandom_range(5, 15);
				put_header(4'(words));
				put_options(words * 4 - FIXED_HEADER, 1'b1);
				put_random($urandom_range(0, 12));
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 8)) begin
						if (segment_draft.size() > 1) void'(segment_draft.pop_back());
					end
				end
			end else begin
				put_random($urandom_range(1, 70));
			end
			random_bytes += segment_draft.size();
			close_segment();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_backlog.size() != 0 || byte_valid) @(posedge clk);
		while (expected_headers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Parsed %0d bytes into %0d segment results, %0d of them malformed,",
			bytes_parsed, results_checked, bad_results);
		$display("with random sender gaps and receiver stalls; %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
